>>> hdl/mmh_pkg.sv
// Package for the min-max heap: sizes, operation and status codes, controller states.
// No dependencies.
package mmh_pkg;
    localparam int CAPACITY = 16;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_EXT_MIN = 2'd1;
    localparam logic [1:0] KIND_EXT_MAX = 2'd2;
    localparam logic [1:0] KIND_PEEK = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic done;
    } stat_t;

    // depth parity of index i: odd depth means a max level
    function automatic logic max_level(input logic [IDX_W:0] i);
        logic [IDX_W+1:0] n;
        logic p;
        n = {1'b0, i} + 1'b1;
        p = 1'b0;
        for (int b = 1; b <= IDX_W + 1; b++)
        begin
            if (n[b])
            begin
                p = b[0];
            end
        end
        return p;
    endfunction

    function automatic logic lt(input logic signed [31:0] a, input logic signed [31:0] b);
        return a < b;
    endfunction

    function automatic logic better(input logic signed [31:0] a,
                                    input logic signed [31:0] b, input logic mx);
        return mx ? (b < a) : (a < b);
    endfunction
endpackage

>>> hdl/min_max_heap_top.sv
// Min-max heap top level: controller plus datapath.
// Each walk step is one hop: to the parent or a grandparent on insert, to a child or
// grandchild on extract.
// Throughput: one item at a time; the next input transfer waits for the result transfer.
// Reset: rst_n asynchronous active low empties the heap and clears the store.
module min_max_heap_top
    import mmh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic        [1:0]  kind,
    input  logic signed [31:0] new_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] taken_value,
    output logic        [1:0]  status,
    output logic signed [31:0] least_now,
    output logic signed [31:0] greatest_now,
    output logic [CNT_W-1:0]   entries_now
);
    cmd_t cmd;
    stat_t stat;

    // controller: one transfer in, walk, one transfer out
    mmh_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
    );

    mmh_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .kind(kind),
        .new_value(new_value), .taken_value(taken_value), .status(status),
        .least_now(least_now), .greatest_now(greatest_now), .entries_now(entries_now)
    );
endmodule

>>> hdl/mmh_ctrl.sv
// Controller FSM for the min-max heap: sequences start, work steps and the result.
// Depends on mmh_pkg.
module mmh_ctrl
    import mmh_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    output logic  out_valid,
    input  logic  out_stall,
    input  stat_t stat,
    output cmd_t  cmd
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_WORK;
                end
            end
            S_WORK:
            begin
                if (stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        out_valid = 1'b0;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.start = in_valid;
            end
            S_WORK:
            begin
                cmd.step = ~stat.done;
                cmd.finish = stat.done;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
            end
            default: ;
        endcase
    end
endmodule

>>> hdl/mmh_dp.sv
// Datapath for the min-max heap: heap registers, count, walk index and result registers.
// Depends on mmh_pkg. Each step handles one parent, grandparent or grandchild hop of bubble-up or trickle-down.
module mmh_dp
    import mmh_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic        [1:0]  kind,
    input  logic signed [31:0] new_value,
    output logic signed [31:0] taken_value,
    output logic        [1:0]  status,
    output logic signed [31:0] least_now,
    output logic signed [31:0] greatest_now,
    output logic [CNT_W-1:0]   entries_now
);
    typedef enum logic [1:0] {
        M_NONE,
        M_UP,
        M_GP,
        M_DOWN
    } mode_t;

    logic signed [31:0] heap_reg [CAPACITY];
    logic [CNT_W-1:0] cnt_reg;
    logic [IDX_W:0] idx_reg;
    logic mx_reg;
    mode_t mode_reg;
    logic signed [31:0] taken_reg;
    logic [1:0] status_reg;

    // store address from a wide walk index
    function automatic logic [IDX_W-1:0] ix(input logic [IDX_W+2:0] i);
        return i[IDX_W-1:0];
    endfunction

    // step evaluation
    logic [IDX_W+2:0] i_w, first, gp, par, best, gc;
    logic do_swap, do_swap2, fin;
    logic [IDX_W+2:0] sw_a, sw_b, sw2_a, sw2_b, nxt_i;
    logic signed [31:0] vb, vi;

    always_comb
    begin
        i_w = {2'b0, idx_reg};
        first = {i_w[IDX_W+1:0], 1'b1};
        gp = (((i_w - 1'b1) >> 1) - 1'b1) >> 1;
        par = (i_w - 1'b1) >> 1;
        best = first;
        gc = '0;
        do_swap = 1'b0;
        do_swap2 = 1'b0;
        fin = 1'b1;
        sw_a = i_w;
        sw_b = i_w;
        sw2_a = i_w;
        sw2_b = i_w;
        nxt_i = i_w;
        vb = '0;
        vi = heap_reg[ix(i_w)];
        case (mode_reg)
            M_UP:
            begin
                fin = 1'b0;
                if (i_w == 0)
                begin
                    fin = 1'b1;
                end
                else if (better(heap_reg[ix(par)], vi, mx_reg))
                begin
                    do_swap = 1'b1;
                    sw_b = par;
                    nxt_i = par;
                end
            end
            M_GP:
            begin
                if (i_w >= 3 && better(vi, heap_reg[ix(gp)], mx_reg))
                begin
                    do_swap = 1'b1;
                    sw_b = gp;
                    nxt_i = gp;
                    fin = 1'b0;
                end
            end
            M_DOWN:
            begin
                if (first < {2'b0, cnt_reg})
                begin
                    if (first + 1'b1 < {2'b0, cnt_reg}
                        && better(heap_reg[ix(first + 1'b1)], heap_reg[ix(first)], mx_reg))
                    begin
                        best = first + 1'b1;
                    end
                    for (int k = 0; k < 4; k++)
                    begin
                        gc = {i_w[IDX_W:0], 2'b11} + (IDX_W+3)'(k);
                        if (gc < {2'b0, cnt_reg}
                            && better(heap_reg[ix(gc)], heap_reg[ix(best)], mx_reg))
                        begin
                            best = gc;
                        end
                    end
                    vb = heap_reg[ix(best)];
                    if (better(vb, vi, mx_reg))
                    begin
                        do_swap = 1'b1;
                        sw_b = best;
                        if (best > first + 1'b1)
                        begin
                            fin = 1'b0;
                            nxt_i = best;
                            // after swap best holds vi, its parent is (best-1)>>1
                            if (better(heap_reg[ix((best - 1'b1) >> 1)], vi, mx_reg))
                            begin
                                do_swap2 = 1'b1;
                                sw2_a = (best - 1'b1) >> 1;
                                sw2_b = best;
                            end
                        end
                    end
                end
            end
            default: fin = 1'b1;
        endcase
    end

    assign stat.done = fin || mode_reg == M_NONE;

    // max index from current array
    logic [IDX_W-1:0] mxi;
    always_comb
    begin
        if (cnt_reg == 1)
        begin
            mxi = '0;
        end
        else if (cnt_reg == 2)
        begin
            mxi = IDX_W'(1);
        end
        else
        begin
            mxi = lt(heap_reg[1], heap_reg[2]) ? IDX_W'(2) : IDX_W'(1);
        end
    end

    logic [CNT_W-1:0] last;
    assign last = cnt_reg - 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < CAPACITY; j++)
            begin
                heap_reg[j] <= '0;
            end
            cnt_reg <= '0;
            idx_reg <= '0;
            mx_reg <= 1'b0;
            taken_reg <= '0;
            status_reg <= ST_OK;
            mode_reg <= M_NONE;
        end
        else if (cmd.start)
        begin
            mode_reg <= M_NONE;
            taken_reg <= '0;
            status_reg <= ST_OK;
            if (kind == KIND_INSERT)
            begin
                if (cnt_reg >= CNT_W'(CAPACITY))
                begin
                    status_reg <= ST_FULL;
                end
                else
                begin
                    heap_reg[cnt_reg[IDX_W-1:0]] <= new_value;
                    cnt_reg <= cnt_reg + 1'b1;
                    idx_reg <= (IDX_W+1)'(cnt_reg);
                    mx_reg <= max_level((IDX_W+1)'(cnt_reg));
                    mode_reg <= M_UP;
                end
            end
            else if (kind == KIND_EXT_MIN || kind == KIND_EXT_MAX)
            begin
                if (cnt_reg == 0)
                begin
                    status_reg <= ST_EMPTY;
                end
                else
                begin
                    logic [IDX_W-1:0] e;
                    e = (kind == KIND_EXT_MIN) ? '0 : mxi;
                    taken_reg <= heap_reg[e];
                    heap_reg[e] <= heap_reg[last[IDX_W-1:0]];
                    cnt_reg <= last;
                    idx_reg <= {1'b0, e};
                    mx_reg <= max_level({1'b0, e});
                    mode_reg <= ({1'b0, e} < last) ? M_DOWN : M_NONE;
                end
            end
        end
        else if (cmd.step || cmd.finish)
        begin
            // a swap with a child ends the walk, so the last cycle may swap too
            if (do_swap)
            begin
                heap_reg[ix(sw_a)] <= heap_reg[ix(sw_b)];
                if (!do_swap2)
                begin
                    heap_reg[ix(sw_b)] <= heap_reg[ix(sw_a)];
                end
            end
            if (do_swap2)
            begin
                heap_reg[ix(sw2_a)] <= vi;
                heap_reg[ix(sw2_b)] <= heap_reg[ix(sw2_a)];
            end
            if (cmd.finish)
            begin
                mode_reg <= M_NONE;
            end
            else
            begin
                idx_reg <= nxt_i[IDX_W:0];
                if (mode_reg == M_UP)
                begin
                    mode_reg <= M_GP;
                    if (do_swap)
                    begin
                        mx_reg <= ~mx_reg;
                    end
                end
            end
        end
    end

    assign taken_value = taken_reg;
    assign status = status_reg;
    assign entries_now = cnt_reg;
    assign least_now = (cnt_reg == 0) ? '0 : heap_reg[0];
    assign greatest_now = (cnt_reg == 0) ? '0 : heap_reg[mxi];
endmodule

>>> hdl/mmh_checker.sv
// Port-level checker for the min-max heap, bound to the top level.
// Depends on mmh_pkg.
module mmh_checker
    import mmh_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic        [1:0]  status,
    input logic signed [31:0] least_now,
    input logic signed [31:0] greatest_now,
    input logic [CNT_W-1:0]   entries_now
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid) else $error("result dropped");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entries_now != 0 |-> least_now <= greatest_now)
        else $error("min above max");
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entries_now <= CNT_W'(CAPACITY) && status <= ST_FULL)
        else $error("count overflow or bad status");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("input taken during result");
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid) else $error("stalled input withdrawn");
endmodule

bind min_max_heap_top mmh_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .least_now(least_now), .greatest_now(greatest_now), .entries_now(entries_now)
);
